// File: design/wl512_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512 generator package
// Shared types and constants: state table, action codes and result beat.
// ----------------------------------------------------------------------------
package wl512_pkg;

    localparam int unsigned WL_WORDS = 16;

    localparam logic [31:0] WL_TEMPER = 32'hDA442D24;

    typedef logic [31:0] word_arr_t [WL_WORDS];

    localparam word_arr_t WL_RESET_TABLE = '{
        32'hED441570, 32'h2BBB76C8, 32'h73276792, 32'h66739C9C,
        32'h6189D44A, 32'h2C1BAC00, 32'h9DEC31E8, 32'hB0100E59,
        32'hCDDF7074, 32'h42C707D0, 32'h6AAE869C, 32'h2F159D0D,
        32'h24AA6EEB, 32'h3786C1C7, 32'hB705D8A4, 32'hC89578C0
    };

    typedef enum logic [1:0] {
        ACT_WORD = 2'd0,
        ACT_BIT  = 2'd1,
        ACT_SEED = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] seed;
    } request_t;

    typedef struct packed {
        logic [31:0] value;
        logic        bit_res;
    } result_t;

endpackage

// File: design/wl512_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512 state core
// Holds the sixteen state words in rotated order, so that the recurrence
// always taps fixed places, plus the buffered bit word and its bit counter.
// Computes one result and the next state per step.
// ----------------------------------------------------------------------------
module wl512_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  wl512_pkg::request_t req,
    output wl512_pkg::result_t  res
);
    import wl512_pkg::*;

    word_arr_t   words_reg;
    word_arr_t   words_next;
    logic [31:0] bit_word_reg;
    logic [31:0] bit_word_next;
    logic [5:0]  bit_next_reg;
    logic [5:0]  bit_next_next;

    logic [31:0] a0;
    logic [31:0] c13;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] a2;
    logic [31:0] d;
    logic [31:0] f;
    logic [31:0] e;
    logic        fetch;
    logic [31:0] bw;
    logic [5:0]  bn;
    logic [4:0]  pos;
    logic [31:0] prod [WL_WORDS/2];

    always_comb
    begin
        a0  = words_reg[0];
        c13 = words_reg[13];
        b   = a0 ^ c13 ^ (a0 << 16) ^ (c13 << 15);
        c   = words_reg[9] ^ (words_reg[9] >> 11);
        a2  = b ^ c;
        d   = a2 ^ ((a2 << 5) & WL_TEMPER);
        f   = words_reg[15];
        e   = f ^ b ^ d ^ (f << 2) ^ (b << 18) ^ (c << 28);
    end

    always_comb
    begin
        fetch = (bit_next_reg == 6'd0) || (bit_next_reg > 6'd32);
        bw    = fetch ? e : bit_word_reg;
        bn    = fetch ? 6'd1 : bit_next_reg;
        pos   = 5'(bn - 6'd1);
    end

    always_comb
    begin
        for (int k = 0; k < WL_WORDS / 2; k++)
        begin
            prod[k] = req.seed * 32'(k + 1);
        end
    end

    always_comb
    begin
        words_next    = words_reg;
        bit_word_next = bit_word_reg;
        bit_next_next = bit_next_reg;
        res.value     = 32'd0;
        res.bit_res   = 1'b0;
        unique case (req.action)
            ACT_WORD:
            begin
                words_next[0] = e;
                words_next[1] = a2;
                for (int i = 2; i < WL_WORDS; i++)
                begin
                    words_next[i] = words_reg[i-1];
                end
                res.value = e;
            end
            ACT_BIT:
            begin
                if (fetch)
                begin
                    words_next[0] = e;
                    words_next[1] = a2;
                    for (int i = 2; i < WL_WORDS; i++)
                    begin
                        words_next[i] = words_reg[i-1];
                    end
                end
                bit_word_next = bw;
                bit_next_next = (bn >= 6'd32) ? 6'd0 : bn + 6'd1;
                res.bit_res   = bw[pos];
                res.value     = bw & (32'd1 << pos);
            end
            ACT_SEED:
            begin
                for (int k = 0; k < WL_WORDS / 2; k++)
                begin
                    words_next[2*k]   = prod[k];
                    words_next[2*k+1] = ~prod[k];
                end
            end
            default:
            begin
                words_next = words_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg    <= WL_RESET_TABLE;
            bit_word_reg <= 32'd0;
            bit_next_reg <= 6'd0;
        end
        else if (step)
        begin
            words_reg    <= words_next;
            bit_word_reg <= bit_word_next;
            bit_next_reg <= bit_next_next;
        end
    end

endmodule

// File: design/well512_random_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512 random generator
// Streaming wrapper around the WELL512 state core.
//
// Input channel s_*: one beat per request. s_tuser carries the action
// (draw word, draw bit, reseed), s_tdata the seed, used only by a reseed.
// Output channel m_*: exactly one beat per request, in order. m_tdata
// carries the value, m_tuser the drawn bit.
// An accepted input beat passes the input register, then the state update and
// result register. Throughput: one beat per cycle while m_tready is high; the
// recurrence taps fixed places of the rotated state words, so each step is
// one pass of xor and shift logic.
// Reset: state words return to the fixed initial table, the bit buffer and
// its counter clear, and both channels empty.
// Stall: when m_tready is low the result holds in the output register, the
// input register fills and then s_tready drops; no beat is lost.
// ----------------------------------------------------------------------------
module well512_random_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [0:0]  m_tuser    // [0] bit_res
);
    import wl512_pkg::*;

    logic     in_vld_reg;
    request_t req_reg;
    logic     out_vld_reg;
    result_t  res_reg;
    result_t  res;
    logic     advance;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            req_reg.action <= s_tuser;
            req_reg.seed   <= s_tdata;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    wl512_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (req_reg),
        .res   (res)
    );

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = res_reg.value;
    assign m_tuser[0] = res_reg.bit_res;

endmodule

// File: tb/wl512_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512 generator testbench package
// Draw tracker: a software copy of the generator state that predicts each
// result beat from the accepted request beats and checks the beats in order.
// ----------------------------------------------------------------------------
package wl512_tb_pkg;

    import wl512_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;

    class well_prng_tracker;

        word_arr_t   state_words;
        logic [3:0]  pos;
        logic [31:0] bit_buf;
        logic [5:0]  bit_cnt;
        result_t     expected_results[$];
        int          errors;

        function new();
            state_words = WL_RESET_TABLE;
            pos         = 4'd0;
            bit_buf     = 32'd0;
            bit_cnt     = 6'd0;
            errors      = 0;
        endfunction

        function logic [31:0] next_word();
            logic [3:0]  p;
            logic [3:0]  ia;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] c;
            logic [31:0] d;
            logic [31:0] e;
            p  = pos;
            a  = state_words[p];
            ia = p + 4'd13;
            c  = state_words[ia];
            b  = a ^ c ^ (a << 16) ^ (c << 15);
            ia = p + 4'd9;
            c  = state_words[ia];
            c  = c ^ (c >> 11);
            a  = b ^ c;
            state_words[p] = a;
            d  = a ^ ((a << 5) & WL_TEMPER);
            p  = p + 4'd15;
            pos = p;
            a  = state_words[p];
            e  = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
            state_words[p] = e;
            return e;
        endfunction

        function void note_request(logic [1:0] act, logic [31:0] seed);
            result_t     res;
            logic [5:0]  idx6;
            logic [4:0]  sh;
            logic [31:0] v;
            res.value   = 32'd0;
            res.bit_res = 1'b0;
            case (act)
                ACT_WORD:
                begin
                    res.value = next_word();
                end
                ACT_BIT:
                begin
                    if (bit_cnt == 6'd0 || bit_cnt > 6'd32)
                    begin
                        bit_buf = next_word();
                        bit_cnt = 6'd1;
                    end
                    idx6        = bit_cnt - 6'd1;
                    sh          = idx6[4:0];
                    res.bit_res = bit_buf[sh];
                    res.value   = bit_buf & (32'd1 << sh);
                    bit_cnt     = (bit_cnt >= 6'd32) ? 6'd0 : bit_cnt + 6'd1;
                end
                ACT_SEED:
                begin
                    for (int k = 1; k <= 8; k++)
                    begin
                        v = seed * k;
                        state_words[2 * k - 2] = v;
                        state_words[2 * k - 1] = ~v;
                    end
                    pos = 4'd0;
                end
                default:
                begin
                end
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [31:0] value, logic bit_res);
            result_t exp_res;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: value %h bit_res %b", value, bit_res);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (value !== exp_res.value)
            begin
                $error("value mismatch: expected %h, actual %h", exp_res.value, value);
                errors++;
            end
            if (bit_res !== exp_res.bit_res)
            begin
                $error("bit_res mismatch: expected %b, actual %b", exp_res.bit_res, bit_res);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

    endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WELL512 generator testbench
// Drives word draws, bit draws, reseeds and the unused action through the
// request stream under random back-pressure and checks every result beat
// against the draw tracker.
// ----------------------------------------------------------------------------
module tb;

    import wl512_pkg::*;
    import wl512_tb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    int send_idle;
    int recv_idle;

    well_prng_tracker tracker;

    well512_random_generator i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tuser[0]);
    end

    task automatic send_request(input logic [1:0] act, input logic [31:0] seed);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= seed;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_request(act, seed);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int n_items);
        int          sent;
        int          run_len;
        int          pick;
        logic [31:0] seed;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                run_len = $urandom_range(1, 8);
                repeat (run_len) send_request(ACT_WORD, $urandom);
            end
            else if (pick < 75)
            begin
                run_len = $urandom_range(1, 40);
                repeat (run_len) send_request(ACT_BIT, $urandom);
            end
            else if (pick < 90)
            begin
                run_len = 1;
                case ($urandom_range(7))
                    0:       seed = 32'h0000_0000;
                    1:       seed = 32'hFFFF_FFFF;
                    default: seed = $urandom;
                endcase
                send_request(ACT_SEED, seed);
            end
            else
            begin
                run_len = 1;
                send_request(ACT_NONE, $urandom);
            end
            sent += run_len;
        end
    endtask

    initial
    begin
        tracker   = new();
        send_idle = 29;
        recv_idle = 85;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 32'd0;
        s_tuser  <= ACT_WORD;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // draws from the reset table, then a bit word carried across a reseed
        send_request(ACT_WORD, 32'h0000_0000);
        send_request(ACT_WORD, 32'hFFFF_FFFF);
        send_request(ACT_BIT,  32'h0000_0000);
        send_request(ACT_BIT,  32'hFFFF_FFFF);
        send_request(ACT_BIT,  32'h5A5A_A5A5);
        send_request(ACT_SEED, 32'h0000_0000);
        send_request(ACT_BIT,  32'h0000_0000);
        send_request(ACT_WORD, 32'h0000_0000);
        send_request(ACT_WORD, 32'h0000_0000);
        send_request(ACT_SEED, 32'hFFFF_FFFF);
        send_request(ACT_WORD, 32'h0000_0000);
        send_request(ACT_BIT,  32'h0000_0000);
        send_request(ACT_NONE, 32'hFFFF_FFFF);
        send_request(ACT_SEED, 32'h8000_0000);
        send_request(ACT_WORD, 32'h0000_0000);
        send_request(ACT_SEED, 32'h0000_0001);
        send_request(ACT_WORD, 32'h0000_0000);
        send_request(ACT_BIT,  32'hFFFF_FFFF);
        send_request(ACT_NONE, 32'h0000_0000);
        send_request(ACT_WORD, 32'hFFFF_FFFF);

        run_random(660);
        wait_drained();

        send_idle = 85;
        recv_idle = 29;
        run_random(660);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        run_random(680);
        wait_drained();

        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
